// ===== rtl/dltrn_pkg.sv =====
// Package for the dense layer training engine: operation codes, datapath
// command codes, configuration indexes and saturation helpers.
// No dependencies.
package dltrn_pkg;

  // fixed-point format
  localparam int FracBits  = 12;
  localparam int ScaleBits = 16;
  localparam int WideBits  = 66;

  // operation codes of an input word
  localparam logic [3:0] OP_WR_W  = 4'd0;
  localparam logic [3:0] OP_WR_B  = 4'd1;
  localparam logic [3:0] OP_WR_X  = 4'd2;
  localparam logic [3:0] OP_WR_U  = 4'd3;
  localparam logic [3:0] OP_FWD   = 4'd4;
  localparam logic [3:0] OP_BWD   = 4'd5;
  localparam logic [3:0] OP_UPD   = 4'd6;
  localparam logic [3:0] OP_RD_Y  = 4'd7;
  localparam logic [3:0] OP_RD_IG = 4'd8;
  localparam logic [3:0] OP_RD_W  = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_NEURONS = 2'd0;
  localparam logic [1:0] CFG_INPUTS  = 2'd1;
  localparam logic [1:0] CFG_ACT     = 2'd2;
  localparam logic [1:0] CFG_SCALE   = 2'd3;

  // configuration reset values
  localparam logic [6:0]  RST_NEURONS = 7'd64;
  localparam logic [10:0] RST_INPUTS  = 11'd1024;
  localparam logic        RST_ACT     = 1'b1;
  localparam logic [15:0] RST_SCALE   = 16'd0;

  // datapath element commands
  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_CLEAR  = 4'd1;
  localparam logic [3:0] K_WR_W   = 4'd2;
  localparam logic [3:0] K_WR_B   = 4'd3;
  localparam logic [3:0] K_WR_X   = 4'd4;
  localparam logic [3:0] K_WR_U   = 4'd5;
  localparam logic [3:0] K_RD     = 4'd6;
  localparam logic [3:0] K_F_MAC  = 4'd7;
  localparam logic [3:0] K_F_BIAS = 4'd8;
  localparam logic [3:0] K_IG_CLR = 4'd9;
  localparam logic [3:0] K_B_BIAS = 4'd10;
  localparam logic [3:0] K_B_MAC  = 4'd11;
  localparam logic [3:0] K_U_W    = 4'd12;
  localparam logic [3:0] K_U_B    = 4'd13;

  // read selection
  localparam logic [1:0] RS_Y  = 2'd0;
  localparam logic [1:0] RS_IG = 2'd1;
  localparam logic [1:0] RS_W  = 2'd2;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] rsel;
  } cmd_t;

  localparam logic signed [WideBits-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [WideBits-1:0] S32_MIN = -66'sd2147483648;

  // saturate a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [WideBits-1:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S32_MIN) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/dense_layer_train_engine.sv =====
// Dense layer training engine: loads, reads and runs forward, backward and update passes.
// Every accepted word gets one result, whose status flags an index error; the passes step
// over the elements and let each multiply element clear the pipeline before the next, and
// a stalled result holds off the next word. After reset a clearing pass over every weight
// address zeroes the gradients, biases and outputs; no word is accepted until it ends.
module dense_layer_train_engine #(
  parameter int MAX_NEURONS = 64,
  parameter int MAX_INPUTS  = 1024,
  parameter int VALUE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         op_i,
  input  logic [5:0]         neuron_i,
  input  logic [9:0]         position_i,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic               status_o
);

  localparam int NW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NCW = $clog2(MAX_NEURONS + 1);
  localparam int ICW = $clog2(MAX_INPUTS + 1);

  logic [6:0]  neurons_q;
  logic [10:0] inputs_q;
  logic        act_q;
  logic [15:0] scale_q;
  logic [NCW-1:0] n_use;
  logic [ICW-1:0] m_use;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neurons_q <= dltrn_pkg::RST_NEURONS;
      inputs_q  <= dltrn_pkg::RST_INPUTS;
      act_q     <= dltrn_pkg::RST_ACT;
      scale_q   <= dltrn_pkg::RST_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dltrn_pkg::CFG_NEURONS: neurons_q <= cfg_data_i[6:0];
        dltrn_pkg::CFG_INPUTS:  inputs_q  <= cfg_data_i[10:0];
        dltrn_pkg::CFG_ACT:     act_q     <= cfg_data_i[0];
        dltrn_pkg::CFG_SCALE:   scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sizes in use, limited to the build maximum
  always_comb begin
    if (32'(neurons_q) > MAX_NEURONS) n_use = NCW'(MAX_NEURONS);
    else n_use = NCW'(neurons_q);
    if (32'(inputs_q) > MAX_INPUTS) m_use = ICW'(MAX_INPUTS);
    else m_use = ICW'(inputs_q);
  end

  dltrn_pkg::cmd_t    cmd;
  logic [NW-1:0]      cmd_n;
  logic [IW-1:0]      cmd_p;
  logic signed [15:0] cmd_value;
  logic signed [31:0] dp_rd_value;

  dltrn_ctrl #(
    .MAX_N(MAX_NEURONS),
    .MAX_I(MAX_INPUTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .neuron_i     (neuron_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .n_use_i      (n_use),
    .m_use_i      (m_use),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .cmd_o        (cmd),
    .cmd_n_o      (cmd_n),
    .cmd_p_o      (cmd_p),
    .cmd_value_o  (cmd_value),
    .dp_rd_value_i(dp_rd_value)
  );

  dltrn_datapath #(
    .MAX_N(MAX_NEURONS),
    .MAX_I(MAX_INPUTS),
    .VB   (VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_n_i    (cmd_n),
    .cmd_p_i    (cmd_p),
    .cmd_value_i(cmd_value),
    .act_i      (act_q),
    .scale_i    (scale_q),
    .rd_value_o (dp_rd_value)
  );

endmodule

// ===== rtl/dltrn_datapath.sv =====
// Datapath of the dense layer engine: all stores, three-stage element
// pipeline (read, multiply, write back) and the neuron accumulator.
// Depends on dltrn_pkg.
module dltrn_datapath #(
  parameter int MAX_N = 64,
  parameter int MAX_I = 1024,
  parameter int VB    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dltrn_pkg::cmd_t     cmd_i,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] cmd_n_i,
  input  logic [((MAX_I > 1) ? $clog2(MAX_I) : 1)-1:0] cmd_p_i,
  input  logic signed [15:0]  cmd_value_i,
  input  logic                act_i,
  input  logic [15:0]         scale_i,
  output logic signed [31:0]  rd_value_o
);

  localparam int NW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int IW = (MAX_I > 1) ? $clog2(MAX_I) : 1;
  localparam int AW = NW + IW;
  localparam int WD = 1 << AW;
  localparam int ND = 1 << NW;
  localparam int ID = 1 << IW;
  localparam int W  = dltrn_pkg::WideBits;
  localparam logic signed [W-1:0] VMAX = (66'sd1 <<< (VB - 1)) - 66'sd1;
  localparam logic signed [W-1:0] VMIN = -VMAX - 66'sd1;

  function automatic logic signed [VB-1:0] satv(input logic signed [W-1:0] x);
    logic signed [VB-1:0] r;
    if (x > VMAX) r = VMAX[VB-1:0];
    else if (x < VMIN) r = VMIN[VB-1:0];
    else r = x[VB-1:0];
    return r;
  endfunction

  // stores
  logic signed [VB-1:0] w_mem  [WD];
  logic signed [31:0]   wg_mem [WD];
  logic signed [VB-1:0] x_mem  [ID];
  logic signed [31:0]   ig_mem [ID];
  logic signed [VB-1:0] b_mem  [ND];
  logic signed [VB-1:0] y_mem  [ND];
  logic signed [VB-1:0] u_mem  [ND];
  logic signed [31:0]   bg_mem [ND];

  // pipeline registers
  logic [3:0]          s1_kind_q, s2_kind_q;
  logic [NW-1:0]       s1_n_q, s2_n_q;
  logic [IW-1:0]       s1_p_q, s2_p_q;
  logic signed [15:0]  s1_v_q, s2_v_q;
  logic [1:0]          rsel_q;

  logic signed [VB-1:0] w_rd_q, x_rd_q, b_rd_q, y_rd_q, u_rd_q;
  logic signed [31:0]   wg_rd_q, ig_rd_q, bg_rd_q;

  logic signed [2*VB-1:0] prod_a_q, prod_b_q;
  logic signed [48:0]     prod_c_q;
  logic signed [31:0]     acc_q, acc_d;
  logic signed [VB-1:0]   dz_q, dz_d;

  logic signed [VB-1:0] mul_a;
  logic signed [31:0]   mul_g;
  logic signed [16:0]   scale_s;

  // stage 0: command in, registered reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_kind_q <= dltrn_pkg::K_NONE;
      s2_kind_q <= dltrn_pkg::K_NONE;
    end else begin
      s1_kind_q <= cmd_i.kind;
      s2_kind_q <= s1_kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_n_q <= cmd_n_i;
    s1_p_q <= cmd_p_i;
    s1_v_q <= cmd_value_i;
    s2_n_q <= s1_n_q;
    s2_p_q <= s1_p_q;
    s2_v_q <= s1_v_q;
    if (cmd_i.kind != dltrn_pkg::K_NONE) begin
      w_rd_q  <= w_mem[{cmd_n_i, cmd_p_i}];
      wg_rd_q <= wg_mem[{cmd_n_i, cmd_p_i}];
      x_rd_q  <= x_mem[cmd_p_i];
      ig_rd_q <= ig_mem[cmd_p_i];
      b_rd_q  <= b_mem[cmd_n_i];
      y_rd_q  <= y_mem[cmd_n_i];
      u_rd_q  <= u_mem[cmd_n_i];
      bg_rd_q <= bg_mem[cmd_n_i];
    end
    if (cmd_i.kind == dltrn_pkg::K_RD) rsel_q <= cmd_i.rsel;
  end

  // stage 1: multipliers
  assign mul_a   = (s1_kind_q == dltrn_pkg::K_B_MAC) ? dz_q : x_rd_q;
  assign mul_g   = (s1_kind_q == dltrn_pkg::K_U_B) ? bg_rd_q : wg_rd_q;
  assign scale_s = $signed({1'b0, scale_i});

  always_ff @(posedge clk_i) begin
    prod_a_q <= mul_a * w_rd_q;
    prod_b_q <= dz_q * x_rd_q;
    prod_c_q <= mul_g * scale_s;
  end

  // stage 2: write back
  logic signed [W-1:0]  pa_w, pb_w, pc_w;
  logic signed [31:0]   mac_fwd, sum_b, wg_new, ig_new, bg_new;
  logic signed [VB-1:0] y_new, w_new, b_new, dz_new, wr_val;

  always_comb begin
    pa_w    = W'(prod_a_q) >>> dltrn_pkg::FracBits;
    pb_w    = W'(prod_b_q) >>> dltrn_pkg::FracBits;
    pc_w    = W'(prod_c_q) >>> dltrn_pkg::ScaleBits;
    mac_fwd = dltrn_pkg::sat32(W'(acc_q) + pa_w);
    sum_b   = dltrn_pkg::sat32(W'(acc_q) + W'(b_rd_q));
    if (act_i && sum_b[31]) sum_b = '0;
    y_new   = satv(W'(sum_b));
    dz_new  = (act_i && (y_rd_q[VB-1] || y_rd_q == '0)) ? '0 : u_rd_q;
    bg_new  = dltrn_pkg::sat32(W'(bg_rd_q) + W'(dz_new));
    wg_new  = dltrn_pkg::sat32(W'(wg_rd_q) + pb_w);
    ig_new  = dltrn_pkg::sat32(W'(ig_rd_q) + pa_w);
    w_new   = satv(W'(w_rd_q) - pc_w);
    b_new   = satv(W'(b_rd_q) - pc_w);
    wr_val  = satv(W'(s2_v_q));
  end

  // write port per store
  logic                 w_we, wg_we, x_we, ig_we, b_we, y_we, u_we, bg_we;
  logic signed [VB-1:0] w_wd, b_wd, y_wd;
  logic signed [31:0]   wg_wd, ig_wd, bg_wd;

  always_comb begin
    w_we = 1'b0; wg_we = 1'b0; x_we = 1'b0; ig_we = 1'b0;
    b_we = 1'b0; y_we = 1'b0; u_we = 1'b0; bg_we = 1'b0;
    w_wd = wr_val; b_wd = wr_val; y_wd = '0;
    wg_wd = '0; ig_wd = '0; bg_wd = '0;
    acc_d = acc_q;
    dz_d  = dz_q;
    unique case (s2_kind_q)
      dltrn_pkg::K_CLEAR: begin
        wg_we = 1'b1; ig_we = 1'b1; b_we = 1'b1; y_we = 1'b1; bg_we = 1'b1;
        b_wd = '0;
      end
      dltrn_pkg::K_WR_W: w_we = 1'b1;
      dltrn_pkg::K_WR_B: b_we = 1'b1;
      dltrn_pkg::K_WR_X: x_we = 1'b1;
      dltrn_pkg::K_WR_U: u_we = 1'b1;
      dltrn_pkg::K_F_MAC: acc_d = mac_fwd;
      dltrn_pkg::K_F_BIAS: begin
        y_we = 1'b1; y_wd = y_new; acc_d = '0;
      end
      dltrn_pkg::K_IG_CLR: ig_we = 1'b1;
      dltrn_pkg::K_B_BIAS: begin
        bg_we = 1'b1; bg_wd = bg_new; dz_d = dz_new;
      end
      dltrn_pkg::K_B_MAC: begin
        wg_we = 1'b1; wg_wd = wg_new; ig_we = 1'b1; ig_wd = ig_new;
      end
      dltrn_pkg::K_U_W: begin
        w_we = 1'b1; w_wd = w_new; wg_we = 1'b1;
      end
      dltrn_pkg::K_U_B: begin
        b_we = 1'b1; b_wd = b_new; bg_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) if (w_we)  w_mem[{s2_n_q, s2_p_q}]  <= w_wd;
  always_ff @(posedge clk_i) if (wg_we) wg_mem[{s2_n_q, s2_p_q}] <= wg_wd;
  always_ff @(posedge clk_i) if (x_we)  x_mem[s2_p_q]  <= wr_val;
  always_ff @(posedge clk_i) if (ig_we) ig_mem[s2_p_q] <= ig_wd;
  always_ff @(posedge clk_i) if (b_we)  b_mem[s2_n_q]  <= b_wd;
  always_ff @(posedge clk_i) if (y_we)  y_mem[s2_n_q]  <= y_wd;
  always_ff @(posedge clk_i) if (u_we)  u_mem[s2_n_q]  <= wr_val;
  always_ff @(posedge clk_i) if (bg_we) bg_mem[s2_n_q] <= bg_wd;

  // neuron accumulator and gradient of the current neuron
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) dz_q <= dz_d;

  // read word, held after the read command
  always_comb begin
    case (rsel_q)
      dltrn_pkg::RS_IG: rd_value_o = ig_rd_q;
      dltrn_pkg::RS_W:  rd_value_o = 32'(w_rd_q);
      default:          rd_value_o = 32'(y_rd_q);
    endcase
  end

endmodule

// ===== rtl/dltrn_ctrl.sv =====
// Controller of the dense layer engine: input decode, index checks, loop
// sequencing over neurons and inputs, clearing pass and result register.
// Depends on dltrn_pkg.
module dltrn_ctrl #(
  parameter int MAX_N = 64,
  parameter int MAX_I = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         op_i,
  input  logic [5:0]         neuron_i,
  input  logic [9:0]         position_i,
  input  logic signed [15:0] value_i,
  input  logic [$clog2(MAX_N+1)-1:0] n_use_i,
  input  logic [$clog2(MAX_I+1)-1:0] m_use_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic               status_o,
  output dltrn_pkg::cmd_t    cmd_o,
  output logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] cmd_n_o,
  output logic [((MAX_I > 1) ? $clog2(MAX_I) : 1)-1:0] cmd_p_o,
  output logic signed [15:0] cmd_value_o,
  input  logic signed [31:0] dp_rd_value_i
);

  localparam int NW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int IW  = (MAX_I > 1) ? $clog2(MAX_I) : 1;
  localparam int AW  = NW + IW;
  localparam int NCW = $clog2(MAX_N + 1);
  localparam int ICW = $clog2(MAX_I + 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_CDRAIN = 4'd1;
  localparam logic [3:0] S_IDLE   = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_FWD    = 4'd4;
  localparam logic [3:0] S_BCLR   = 4'd5;
  localparam logic [3:0] S_BWD    = 4'd6;
  localparam logic [3:0] S_UPD    = 4'd7;
  localparam logic [3:0] S_WAIT   = 4'd8;
  localparam logic [3:0] S_POST   = 4'd9;

  localparam logic [1:0] PACE = 2'd2;

  logic [3:0]     state_q, state_d;
  logic [NCW-1:0] i_q, i_d;
  logic [ICW-1:0] j_q, j_d;
  logic           hb_q, hb_d;
  logic [1:0]     pace_q, pace_d;
  logic [AW-1:0]  cc_q, cc_d;
  logic           bad_q, bad_d;
  logic           use_rd_q, use_rd_d;
  logic [3:0]     op_q;
  logic [5:0]     nr_q;
  logic [9:0]     ps_q;
  logic signed [15:0] val_q;
  logic           out_valid_q;
  logic signed [31:0] out_value_q;
  logic           out_status_q;
  logic           nok, pok, post;

  assign nok = 32'(nr_q) < 32'(n_use_i);
  assign pok = 32'(ps_q) < 32'(m_use_i);
  assign post = (state_q == S_POST) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign cmd_value_o = val_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    hb_d     = hb_q;
    pace_d   = (pace_q != 2'd0) ? pace_q - 2'd1 : 2'd0;
    cc_d     = cc_q;
    bad_d    = bad_q;
    use_rd_d = use_rd_q;
    cmd_o.kind = dltrn_pkg::K_NONE;
    cmd_o.rsel = dltrn_pkg::RS_Y;
    cmd_n_o  = NW'(nr_q);
    cmd_p_o  = IW'(ps_q);
    unique case (state_q) inside
      S_CLEAR: begin
        cmd_o.kind = dltrn_pkg::K_CLEAR;
        cmd_n_o = cc_q[AW-1:IW];
        cmd_p_o = cc_q[IW-1:0];
        cc_d = cc_q + 1'b1;
        if (cc_q == '1) begin
          pace_d  = PACE;
          state_d = S_CDRAIN;
        end
      end
      S_CDRAIN: if (pace_q == 2'd0) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        bad_d = 1'b0; use_rd_d = 1'b0;
        i_d = '0; j_d = '0; hb_d = 1'b0;
        state_d = S_WAIT;
        unique case (op_q) inside
          dltrn_pkg::OP_WR_W, dltrn_pkg::OP_WR_B, dltrn_pkg::OP_WR_X,
          dltrn_pkg::OP_WR_U, dltrn_pkg::OP_RD_Y, dltrn_pkg::OP_RD_IG,
          dltrn_pkg::OP_RD_W: begin
            if (((op_q == dltrn_pkg::OP_WR_W || op_q == dltrn_pkg::OP_RD_W) && nok && pok) ||
                ((op_q == dltrn_pkg::OP_WR_B || op_q == dltrn_pkg::OP_WR_U ||
                  op_q == dltrn_pkg::OP_RD_Y) && nok) ||
                ((op_q == dltrn_pkg::OP_WR_X || op_q == dltrn_pkg::OP_RD_IG) && pok)) begin
              pace_d = PACE;
              unique case (op_q)
                dltrn_pkg::OP_WR_W: cmd_o.kind = dltrn_pkg::K_WR_W;
                dltrn_pkg::OP_WR_B: cmd_o.kind = dltrn_pkg::K_WR_B;
                dltrn_pkg::OP_WR_X: cmd_o.kind = dltrn_pkg::K_WR_X;
                dltrn_pkg::OP_WR_U: cmd_o.kind = dltrn_pkg::K_WR_U;
                default: begin
                  cmd_o.kind = dltrn_pkg::K_RD;
                  use_rd_d = 1'b1;
                  if (op_q == dltrn_pkg::OP_RD_IG) cmd_o.rsel = dltrn_pkg::RS_IG;
                  else if (op_q == dltrn_pkg::OP_RD_W) cmd_o.rsel = dltrn_pkg::RS_W;
                  else cmd_o.rsel = dltrn_pkg::RS_Y;
                end
              endcase
            end else begin
              bad_d = 1'b1;
            end
          end
          dltrn_pkg::OP_FWD: state_d = S_FWD;
          dltrn_pkg::OP_BWD: state_d = S_BCLR;
          dltrn_pkg::OP_UPD: state_d = S_UPD;
          default: ;
        endcase
      end
      S_FWD, S_UPD: begin
        if (pace_q == 2'd0) begin
          cmd_n_o = NW'(i_q);
          cmd_p_o = IW'(j_q);
          if (i_q == n_use_i) begin
            state_d = S_WAIT;
          end else if (j_q != m_use_i) begin
            cmd_o.kind = (state_q == S_FWD) ? dltrn_pkg::K_F_MAC : dltrn_pkg::K_U_W;
            j_d = j_q + 1'b1;
            pace_d = PACE;
          end else begin
            cmd_o.kind = (state_q == S_FWD) ? dltrn_pkg::K_F_BIAS : dltrn_pkg::K_U_B;
            j_d = '0;
            i_d = i_q + 1'b1;
            pace_d = PACE;
          end
        end
      end
      S_BCLR: begin
        // input gradient cleared one entry a cycle
        cmd_p_o = IW'(j_q);
        if (j_q == m_use_i) begin
          j_d = '0;
          state_d = S_BWD;
        end else begin
          cmd_o.kind = dltrn_pkg::K_IG_CLR;
          j_d = j_q + 1'b1;
        end
      end
      S_BWD: begin
        if (pace_q == 2'd0) begin
          cmd_n_o = NW'(i_q);
          cmd_p_o = IW'(j_q);
          if (i_q == n_use_i) begin
            state_d = S_WAIT;
          end else if (!hb_q) begin
            cmd_o.kind = dltrn_pkg::K_B_BIAS;
            hb_d = 1'b1;
            pace_d = PACE;
          end else if (j_q != m_use_i) begin
            cmd_o.kind = dltrn_pkg::K_B_MAC;
            j_d = j_q + 1'b1;
            pace_d = PACE;
          end else begin
            i_d = i_q + 1'b1;
            j_d = '0;
            hb_d = 1'b0;
          end
        end
      end
      S_WAIT: if (pace_q == 2'd0) state_d = S_POST;
      S_POST: if (post) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      i_q         <= '0;
      j_q         <= '0;
      hb_q        <= 1'b0;
      pace_q      <= 2'd0;
      cc_q        <= '0;
      bad_q       <= 1'b0;
      use_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      hb_q     <= hb_d;
      pace_q   <= pace_d;
      cc_q     <= cc_d;
      bad_q    <= bad_d;
      use_rd_q <= use_rd_d;
      if (post) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // input word capture and result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= op_i;
      nr_q  <= neuron_i;
      ps_q  <= position_i;
      val_q <= value_i;
    end
    if (post) begin
      out_value_q  <= use_rd_q ? dp_rd_value_i : '0;
      out_status_q <= bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;

endmodule
